@@ rtl/esc_pkg.sv @@
package esc_pkg;

  localparam int COUNT_MODULUS = 1024;
  localparam int CntW = $clog2(COUNT_MODULUS);

  localparam int HistW = 13;
  localparam logic [HistW-1:0] HistFire = 13'h1000;

  localparam logic [7:0] SegBlank = 8'hFF;

  // reciprocal constants, exact for values below 21399
  localparam int NumW = 14;
  localparam int RecipW = 17;
  localparam int ProdW = NumW + RecipW;
  localparam logic [RecipW-1:0] Div10Mul = 17'd52429;
  localparam int Div10Sh = 19;
  localparam logic [RecipW-1:0] Div100Mul = 17'd5243;
  localparam int Div100Sh = 19;
  localparam logic [RecipW-1:0] Div1000Mul = 17'd8389;
  localparam int Div1000Sh = 23;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  localparam logic [1:0] PhaseUpPrev = 2'd1;
  localparam logic [1:0] PhaseDownPrev = 2'd2;
  localparam logic [1:0] PhaseDetent = 2'd3;

  typedef struct packed {
    logic       button0_level;
    logic       button1_level;
    logic [3:0] encoder_bits;
  } esc_in_t;

  typedef struct packed {
    logic [9:0] count_value;
    logic [7:0] ones_segments;
    logic [7:0] tens_segments;
    logic [7:0] hundreds_segments;
    logic [7:0] thousands_segments;
    logic [3:0] digit_enables;
    logic [1:0] mode_flags;
  } esc_out_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h98;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

  function automatic dir_e phase_dir(input logic [1:0] prev, input logic [1:0] now);
    dir_e dir;
    dir = DIR_NONE;
    if (now == PhaseDetent) begin
      if (prev == PhaseUpPrev) begin
        dir = DIR_UP;
      end else if (prev == PhaseDownPrev) begin
        dir = DIR_DOWN;
      end
    end
    return dir;
  endfunction

endpackage

@@ rtl/encoder_step_counter_display.sv @@
// Encoder step counter with four-digit seven-segment display.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per sample tick,
// carrying the two raw button levels and the 4-bit encoder readout.
// Output channel (out_valid_o/out_ready_i/out_data_o): one beat per input
// beat, in order: the counter after this tick, four active-low segment codes
// with leading-zero blanking, digit enables and the two mode flags.
//
// The beat lands in the input register, then the state update and display
// decode feed the result register. Throughput is one beat per cycle while
// the receiver does not stall; the whole update is one pass of small logic on tiny state.
//
// Reset clears debounce histories, mode flags, previous encoder phases and
// the counter, and empties both pipeline registers.
// When the receiver stalls, the result register holds its beat, the input
// register still takes one more beat, and then in_ready_o drops until the
// output drains. Beats are never dropped or duplicated.
module encoder_step_counter_display (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  esc_pkg::esc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output esc_pkg::esc_out_t out_data_o
);
  import esc_pkg::*;

  logic             in_valid_q;
  esc_in_t          in_q;
  logic             out_valid_q;
  esc_out_t         out_q, out_d;
  logic             advance;

  logic [HistW-1:0] hist0_q, hist0_d, hist1_q, hist1_d;
  logic [1:0]       flags_q, flags_d;
  logic [1:0]       prev_a_q, prev_b_q;
  logic [CntW-1:0]  cnt_q, cnt_d;

  dir_e             dir_a, dir_b, dir;
  logic [CntW:0]    step, sum_up, sum_dn;
  logic [NumW-1:0]  num;
  logic [ProdW-1:0] prod1, prod2, prod3;
  logic [NumW-1:0]  q1, q2, q3;
  logic [3:0]       d0, d1, d2, d3;
  logic [3:0]       en;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    hist0_d = {hist0_q[HistW-2:0], in_q.button0_level};
    hist1_d = {hist1_q[HistW-2:0], in_q.button1_level};
    flags_d = flags_q ^ {hist1_d == HistFire, hist0_d == HistFire};

    if (flags_d[0]) begin
      step = (CntW+1)'(2);
    end else if (flags_d[1]) begin
      step = (CntW+1)'(4);
    end else begin
      step = (CntW+1)'(1);
    end

    dir_a = phase_dir(prev_a_q, in_q.encoder_bits[1:0]);
    dir_b = phase_dir(prev_b_q, in_q.encoder_bits[3:2]);
    dir   = (dir_a != DIR_NONE) ? dir_a : dir_b;

    sum_up = {1'b0, cnt_q} + step;
    if (sum_up >= (CntW+1)'(COUNT_MODULUS)) begin
      sum_up = sum_up - (CntW+1)'(COUNT_MODULUS);
    end
    if ({1'b0, cnt_q} < step) begin
      sum_dn = {1'b0, cnt_q} + (CntW+1)'(COUNT_MODULUS) - step;
    end else begin
      sum_dn = {1'b0, cnt_q} - step;
    end

    unique case (dir)
      DIR_UP:   cnt_d = sum_up[CntW-1:0];
      DIR_DOWN: cnt_d = sum_dn[CntW-1:0];
      default:  cnt_d = cnt_q;
    endcase
  end

  always_comb begin
    num   = NumW'(cnt_d);
    prod1 = ProdW'(num) * ProdW'(Div10Mul);
    prod2 = ProdW'(num) * ProdW'(Div100Mul);
    prod3 = ProdW'(num) * ProdW'(Div1000Mul);
    q1    = NumW'(prod1 >> Div10Sh);
    q2    = NumW'(prod2 >> Div100Sh);
    q3    = NumW'(prod3 >> Div1000Sh);
    d0    = 4'(num - ((q1 << 3) + (q1 << 1)));
    d1    = 4'(q1 - ((q2 << 3) + (q2 << 1)));
    d2    = 4'(q2 - ((q3 << 3) + (q3 << 1)));
    d3    = 4'(q3);
    en    = {q3 != '0, q2 != '0, q1 != '0, 1'b1};

    out_d.count_value        = 10'(cnt_d);
    out_d.ones_segments      = seg_code(d0);
    out_d.tens_segments      = en[1] ? seg_code(d1) : SegBlank;
    out_d.hundreds_segments  = en[2] ? seg_code(d2) : SegBlank;
    out_d.thousands_segments = en[3] ? seg_code(d3) : SegBlank;
    out_d.digit_enables      = en;
    out_d.mode_flags         = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hist0_q     <= '0;
      hist1_q     <= '0;
      flags_q     <= '0;
      prev_a_q    <= '0;
      prev_b_q    <= '0;
      cnt_q       <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        hist0_q     <= hist0_d;
        hist1_q     <= hist1_d;
        flags_q     <= flags_d;
        prev_a_q    <= in_q.encoder_bits[1:0];
        prev_b_q    <= in_q.encoder_bits[3:2];
        cnt_q       <= cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

@@ rtl/esc_checker.sv @@
module esc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input esc_pkg::esc_out_t out_data_o
);
  import esc_pkg::*;

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // ones digit always shown, enables contiguous from the bottom
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.digit_enables[0] &&
      (!out_data_o.digit_enables[3] || out_data_o.digit_enables[2]) &&
      (!out_data_o.digit_enables[2] || out_data_o.digit_enables[1]))
    else $error("digit enables not contiguous");

  // with the tens digit blanked, the tens, hundreds and thousands digits drive all segments off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.digit_enables[1] |->
      out_data_o.tens_segments == SegBlank &&
      out_data_o.hundreds_segments == SegBlank &&
      out_data_o.thousands_segments == SegBlank)
    else $error("blanked digit not dark");

  // a result sitting unaccepted, once the input stage takes a beat, blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_i && in_ready_o |=>
      out_ready_i || !in_ready_o)
    else $error("input accepted past a full pipeline");

endmodule

bind encoder_step_counter_display esc_checker u_esc_checker (.*);
